>>> rtl/i2ctrf_pkg.sv
// ----------------------------------------------------------------------------
// i2ctrf_pkg: shared types and constants of the i2c target register file
// pin and result payloads, configuration bundle, bus phase codes
// ----------------------------------------------------------------------------
`default_nettype none

package i2ctrf_pkg;

    // register store geometry
    localparam int PTR_W       = 9;
    localparam int STORE_DEPTH = 1 << PTR_W;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_IDX  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOUCH_VAL  = 2'd3;
    localparam int CFG_DATA_W = 9;

    // configuration reset values
    localparam logic [6:0] DEV_ADDR_A_RST = 7'h14;
    localparam logic [6:0] DEV_ADDR_B_RST = 7'h5B;
    localparam logic [8:0] TOUCH_IDX_RST  = 9'h14E;
    localparam logic [7:0] TOUCH_VAL_RST  = 8'h81;

    // pin bit positions
    localparam int PIN_RST_BIT = 0;
    localparam int PIN_SDA_BIT = 2;
    localparam int PIN_SCL_BIT = 3;

    // bit phase codes
    localparam logic [2:0] BP_IDLE     = 3'd0;
    localparam logic [2:0] BP_RCV      = 3'd1;
    localparam logic [2:0] BP_SND      = 3'd2;
    localparam logic [2:0] BP_RCV_ACK  = 3'd3;
    localparam logic [2:0] BP_SND_ACK  = 3'd4;
    localparam logic [2:0] BP_SKIP_ACK = 3'd5;

    // transfer phase codes
    localparam logic [2:0] TP_ADDR   = 3'd0;
    localparam logic [2:0] TP_PTR_HI = 3'd1;
    localparam logic [2:0] TP_PTR_LO = 3'd2;
    localparam logic [2:0] TP_RX     = 3'd3;
    localparam logic [2:0] TP_TX     = 3'd4;

    typedef struct packed {
        logic [7:0] port_value;
        logic       touch_down;
    } pin_req_t;

    typedef struct packed {
        logic [7:0] port_out;
        logic [2:0] bus_phase;
    } res_t;

    typedef struct packed {
        logic [6:0] dev_addr_a;
        logic [6:0] dev_addr_b;
        logic [8:0] touch_idx;
        logic [7:0] touch_val;
    } cfg_t;

    // classified pin sample handed from front to back
    typedef struct packed {
        logic [7:0] port_value;
        logic       touch_down;
        logic       bus_en;
        logic       scl;
        logic       sda;
    } pin_cls_t;

endpackage

`default_nettype wire

>>> rtl/i2c_target_register_file_top.sv
// ----------------------------------------------------------------------------
// i2c_target_register_file_top: bit-level i2c target with a byte register file
// pin samples in, driven pin byte and bus phase out, four config registers
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   pin       pin_valid/pin_ready    pin (port_value, touch_down)
//   res       res_valid/res_ready    res (port_out, bus_phase)
//   cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
// - one request per cycle sustained while results are taken; a result is
//   registered once its request at the head of the two-entry intake queue is consumed
// - the byte fetch for a read goes through the store's registered read port
//   and is folded into the shift byte by the following sample, so it adds no stall
// - after reset the 512-byte store is swept to zero, one byte a cycle;
//   pin_ready stays low meanwhile, config writes are taken
// - a stalled result holds in the output register while the queue keeps filling
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_target_register_file_top (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  pin_valid,
    output logic                                       pin_ready,
    input  wire i2ctrf_pkg::pin_req_t                  pin,
    output logic                                       res_valid,
    input  wire logic                                  res_ready,
    output i2ctrf_pkg::res_t                           res,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [i2ctrf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [i2ctrf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import i2ctrf_pkg::*;

    // configuration registers
    cfg_t     cfg_reg;
    logic     clr_busy;

    // intake queue to engine
    logic     q_valid;
    logic     q_ready;
    pin_cls_t q_data;

    // config writes are always taken; the sender must issue them only while the
    // engine has nothing in flight, and the block itself does not enforce that
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dev_addr_a <= DEV_ADDR_A_RST;
            cfg_reg.dev_addr_b <= DEV_ADDR_B_RST;
            cfg_reg.touch_idx  <= TOUCH_IDX_RST;
            cfg_reg.touch_val  <= TOUCH_VAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_DEV_ADDR_A: cfg_reg.dev_addr_a <= cfg_data[6:0];
                CFG_DEV_ADDR_B: cfg_reg.dev_addr_b <= cfg_data[6:0];
                CFG_TOUCH_IDX:  cfg_reg.touch_idx  <= cfg_data[8:0];
                CFG_TOUCH_VAL:  cfg_reg.touch_val  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // front: accepts pin requests, splits out bus pins, queues them
    i2ctrf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pin_valid (pin_valid),
        .pin_ready (pin_ready),
        .pin       (pin),
        .clr_busy  (clr_busy),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data)
    );

    // back: bus protocol engine, register store and result register
    i2ctrf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .clr_busy  (clr_busy),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

endmodule

`default_nettype wire

>>> rtl/i2ctrf_front.sv
// ----------------------------------------------------------------------------
// i2ctrf_front: request intake
// takes pin requests, splits out the bus pins and holds them in a two-entry queue
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctrf_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 pin_valid,
    output logic                      pin_ready,
    input  wire i2ctrf_pkg::pin_req_t pin,
    input  wire logic                 clr_busy,
    output logic                      q_valid,
    input  wire logic                 q_ready,
    output i2ctrf_pkg::pin_cls_t      q_data
);
    import i2ctrf_pkg::*;

    pin_cls_t   slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;
    pin_cls_t   cls;

    // classify the pin byte
    always_comb
    begin
        cls.port_value = pin.port_value;
        cls.touch_down = pin.touch_down;
        cls.bus_en     = pin.port_value[PIN_RST_BIT];
        cls.scl        = pin.port_value[PIN_SCL_BIT];
        cls.sda        = pin.port_value[PIN_SDA_BIT];
    end

    assign pin_ready = (count_reg != 2'd2) && !clr_busy;
    assign push      = pin_valid && pin_ready;
    assign q_valid   = (count_reg != 2'd0);
    assign pop       = q_valid && q_ready;
    assign q_data    = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

>>> rtl/i2ctrf_back.sv
// ----------------------------------------------------------------------------
// i2ctrf_back: bus engine and register store
// decodes scl/sda events per sample, runs the byte protocol, owns the store
// ----------------------------------------------------------------------------
`default_nettype none

module i2ctrf_back (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire i2ctrf_pkg::cfg_t     cfg,
    input  wire logic                 q_valid,
    output logic                      q_ready,
    input  wire i2ctrf_pkg::pin_cls_t q_data,
    output logic                      clr_busy,
    output logic                      res_valid,
    input  wire logic                 res_ready,
    output i2ctrf_pkg::res_t          res
);
    import i2ctrf_pkg::*;

    logic [7:0]       store [STORE_DEPTH];
    logic [7:0]       mem_q_reg;

    logic [2:0]       bp_reg, bp_next;
    logic [2:0]       tp_reg, tp_next;
    logic [7:0]       shift_reg, shift_next;
    logic [3:0]       cnt_reg, cnt_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [7:0]       prev_reg, prev_next;
    logic             load_pend_reg, load_pend_next;
    logic             clr_busy_reg;
    logic [PTR_W-1:0] clr_addr_reg;
    logic             res_valid_reg;
    res_t             res_reg;

    logic             fire;
    logic [7:0]       sh;
    logic [7:0]       p;
    logic [7:0]       b;
    logic [4:0]       cnt_inc;
    logic             step_we;
    logic [7:0]       step_wd;
    logic             mem_re;
    logic             mem_we;
    logic [PTR_W-1:0] mem_wa;
    logic [7:0]       mem_wd;
    logic             scl_rise;
    logic             touch_hit;

    assign fire      = q_valid && (!res_valid_reg || res_ready) && !clr_busy_reg;
    assign q_ready   = fire;
    assign clr_busy  = clr_busy_reg;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // a byte fetched by the previous sample lands here
    assign sh        = load_pend_reg ? mem_q_reg : shift_reg;
    assign cnt_inc   = {1'b0, cnt_reg} + 5'd1;
    assign scl_rise  = q_data.scl && !prev_reg[PIN_SCL_BIT];
    assign touch_hit = (ptr_reg == cfg.touch_idx);

    always_comb
    begin
        bp_next        = bp_reg;
        tp_next        = tp_reg;
        shift_next     = sh;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        load_pend_next = 1'b0;
        step_we        = 1'b0;
        step_wd        = 8'h00;
        mem_re         = 1'b0;
        p              = q_data.port_value;
        b              = {sh[6:0], q_data.sda};

        if (q_data.bus_en)
        begin
            if (scl_rise)
            begin
                case (bp_reg)
                    BP_SND:
                    begin
                        p[PIN_SDA_BIT] = sh[7];
                        shift_next     = {sh[6:0], 1'b0};
                        cnt_next       = cnt_inc[3:0];
                        if (cnt_inc >= 5'd8)
                        begin
                            bp_next        = BP_RCV_ACK;
                            mem_re         = 1'b1;
                            load_pend_next = 1'b1;
                            cnt_next       = 4'd0;
                            ptr_next       = ptr_reg + 1'b1;
                        end
                    end
                    BP_RCV:
                    begin
                        shift_next = b;
                        cnt_next   = cnt_inc[3:0];
                        if (cnt_inc >= 5'd8)
                        begin
                            case (tp_reg)
                                TP_ADDR:
                                begin
                                    if (b[7:1] == cfg.dev_addr_a || b[7:1] == cfg.dev_addr_b)
                                    begin
                                        tp_next = b[0] ? TP_TX : TP_PTR_HI;
                                        bp_next = BP_SND_ACK;
                                    end
                                    else
                                    begin
                                        bp_next = BP_SKIP_ACK;
                                    end
                                end
                                TP_PTR_HI:
                                begin
                                    // only bit 0 of the high byte survives, as pointer bit 8
                                    ptr_next = PTR_W'({b[0], 8'h00});
                                    tp_next  = TP_PTR_LO;
                                    bp_next  = BP_SND_ACK;
                                end
                                TP_PTR_LO:
                                begin
                                    ptr_next = ptr_reg | PTR_W'(b);
                                    tp_next  = TP_RX;
                                    bp_next  = BP_SND_ACK;
                                end
                                TP_RX:
                                begin
                                    step_we  = 1'b1;
                                    step_wd  = b;
                                    ptr_next = ptr_reg + 1'b1;
                                    bp_next  = BP_SND_ACK;
                                end
                                default:
                                begin
                                    // byte while sending data is dropped
                                end
                            endcase
                            shift_next = 8'h00;
                            cnt_next   = 4'd0;
                        end
                    end
                    BP_SND_ACK:
                    begin
                        p[PIN_SDA_BIT] = 1'b1;
                        if (tp_reg == TP_TX)
                        begin
                            if (touch_hit)
                            begin
                                step_we    = 1'b1;
                                step_wd    = q_data.touch_down ? cfg.touch_val : 8'h00;
                                shift_next = step_wd;
                            end
                            else
                            begin
                                mem_re         = 1'b1;
                                load_pend_next = 1'b1;
                            end
                            ptr_next = ptr_reg + 1'b1;
                            bp_next  = BP_SND;
                        end
                        else
                        begin
                            bp_next = BP_RCV;
                        end
                    end
                    BP_RCV_ACK:
                    begin
                        bp_next = BP_SND;
                    end
                    default:
                    begin
                        bp_next = BP_IDLE;
                    end
                endcase
            end
            else if (q_data.sda != prev_reg[PIN_SDA_BIT] && q_data.scl)
            begin
                if (q_data.sda)
                begin
                    // stop
                    bp_next = BP_IDLE;
                end
                else
                begin
                    // start
                    shift_next = 8'h00;
                    cnt_next   = 4'd0;
                    bp_next    = BP_RCV;
                    tp_next    = TP_ADDR;
                end
            end
        end
        prev_next = p;
    end

    // single write port shared with the clearing sweep
    assign mem_we = clr_busy_reg || (fire && step_we);
    assign mem_wa = clr_busy_reg ? clr_addr_reg : ptr_reg;
    assign mem_wd = clr_busy_reg ? 8'h00 : step_wd;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[mem_wa] <= mem_wd;
        end
        if (fire && mem_re)
        begin
            mem_q_reg <= store[ptr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bp_reg        <= BP_IDLE;
            tp_reg        <= TP_ADDR;
            shift_reg     <= 8'h00;
            cnt_reg       <= 4'd0;
            ptr_reg       <= '0;
            prev_reg      <= 8'h00;
            load_pend_reg <= 1'b0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {PTR_W{1'b1}})
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (fire)
            begin
                bp_reg        <= bp_next;
                tp_reg        <= tp_next;
                shift_reg     <= shift_next;
                cnt_reg       <= cnt_next;
                ptr_reg       <= ptr_next;
                prev_reg      <= prev_next;
                load_pend_reg <= load_pend_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg.port_out  <= prev_next;
            res_reg.bus_phase <= bp_next;
        end
    end

`ifndef SYNTHESIS
    a_no_step_while_clearing : assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !fire)
        else $error("sample consumed during store clearing");

    a_load_only_before_send : assert property (@(posedge clk) disable iff (!rst_n)
        load_pend_reg |-> (bp_reg == BP_RCV_ACK || bp_reg == BP_SND))
        else $error("pending byte fetch outside a send phase");

    a_bit_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < 4'd8)
        else $error("bit count past a full byte");

    a_step_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> res_valid_reg)
        else $error("consumed sample produced no result");
`endif

endmodule

`default_nettype wire

>>> test/tb_i2c_target_register_file_top.sv
// ----------------------------------------------------------------------------
// tb_i2c_target_register_file_top: self-checking bench for the i2c target
// drives pin-sample requests shaped as i2c bus traffic (start, address,
// pointer, data, read-back, stop) mixed with noise and broken sequences, and
// checks every result against a typed expectation or a cycle-free predictor of the target
// ----------------------------------------------------------------------------
`default_nettype none

module tb_i2c_target_register_file_top;

    import i2ctrf_pkg::*;

    // long receiver hold-off used to fill the intake queue
    localparam int LONG_HOLD_CYCLES = 300;

    // ------------------------------------------------------------------------
    // clock, reset and block ports; every input known from time zero
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  pin_valid = 1'b0;
    logic                  pin_ready;
    pin_req_t              pin = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    res_t                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    always #5 clk = ~clk;

    i2c_target_register_file_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pin_valid (pin_valid),
        .pin_ready (pin_ready),
        .pin       (pin),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // predictor state: settings, bus decoder state and the register image
    // ------------------------------------------------------------------------
    logic [6:0] addr_a;
    logic [6:0] addr_b;
    logic [8:0] touch_idx;
    logic [7:0] touch_val;

    logic [2:0] bit_state;
    logic [2:0] xfer_state;
    logic [7:0] shift_reg;
    logic [3:0] shift_count;
    logic [PTR_W-1:0] reg_ptr;
    logic [7:0] last_pins;
    logic [7:0] reg_image [0:STORE_DEPTH-1];

    // expected results, oldest first
    res_t pending_results [$];

    int  pins_sent = 0;
    int  mismatches = 0;
    bit  quiet = 1'b0;      // no idling on either side in the last part
    bit  hold_long = 1'b0;  // asks the receiver for one long hold-off

    // ------------------------------------------------------------------------
    // directed table: reset pin low, edges in idle, stop, start, a matching
    // write address and its acknowledge; want is typed only where it is
    // plain from the pins, other rows go through the predictor
    // ------------------------------------------------------------------------
    typedef struct packed {
        pin_req_t req;
        logic     check;
        res_t     want;
    } dir_row_t;

    dir_row_t directed_rows [0:24] = '{
        {8'h00, 1'b0, 1'b1, 8'h00, BP_IDLE},  // all pins low, reset pin low
        {8'hFE, 1'b1, 1'b1, 8'hFE, BP_IDLE},  // reset pin low: only recorded
        {8'hFF, 1'b1, 1'b1, 8'hFF, BP_IDLE},  // scl and sda unchanged since last byte
        {8'hF3, 1'b0, 1'b1, 8'hF3, BP_IDLE},  // sda change with scl low
        {8'h09, 1'b1, 1'b1, 8'h09, BP_IDLE},  // scl rise while idle
        {8'h0D, 1'b0, 1'b1, 8'h0D, BP_IDLE},  // stop condition
        {8'h09, 1'b0, 1'b1, 8'h09, BP_RCV},   // start condition
        // write address 0x14 (byte 0x28), msb first
        {8'h01, 1'b1, 1'b0, 8'h00, BP_IDLE},
        {8'h09, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h03, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h0B, 1'b1, 1'b0, 8'h00, BP_IDLE},
        {8'h05, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h0D, 1'b1, 1'b0, 8'h00, BP_IDLE},
        {8'h01, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h09, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'hF5, 1'b1, 1'b0, 8'h00, BP_IDLE},
        {8'hFD, 1'b1, 1'b0, 8'h00, BP_IDLE},
        {8'h01, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h09, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h01, 1'b1, 1'b0, 8'h00, BP_IDLE},
        {8'h09, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h01, 1'b0, 1'b0, 8'h00, BP_IDLE},
        {8'h09, 1'b1, 1'b0, 8'h00, BP_IDLE},
        {8'h01, 1'b0, 1'b0, 8'h00, BP_IDLE},  // scl low in the ack slot
        {8'h09, 1'b1, 1'b1, 8'h0D, BP_RCV}    // ack rise: target drives sda high
    };

    // ------------------------------------------------------------------------
    // predictor: one pin sample in, driven pin byte and bit phase out
    // ------------------------------------------------------------------------
    function automatic res_t target_step(pin_req_t s);
        logic [7:0] p;
        res_t       r;
        p = s.port_value;
        if (p[PIN_RST_BIT])
        begin
            if (p[PIN_SCL_BIT] && !last_pins[PIN_SCL_BIT])
            begin
                case (bit_state)
                    BP_SND:
                    begin
                        p[PIN_SDA_BIT] = shift_reg[7];
                        shift_reg = shift_reg << 1;
                        shift_count = shift_count + 4'd1;
                        if (shift_count >= 4'd8)
                        begin
                            bit_state = BP_RCV_ACK;
                            shift_reg = reg_image[reg_ptr];
                            shift_count = '0;
                            reg_ptr = reg_ptr + 1'b1;
                        end
                    end
                    BP_RCV:
                    begin
                        shift_reg = {shift_reg[6:0], p[PIN_SDA_BIT]};
                        shift_count = shift_count + 4'd1;
                        if (shift_count >= 4'd8)
                        begin
                            // whole byte in: meaning depends on transfer phase
                            case (xfer_state)
                                TP_ADDR:
                                begin
                                    if (shift_reg[7:1] == addr_a || shift_reg[7:1] == addr_b)
                                    begin
                                        xfer_state = shift_reg[0] ? TP_TX : TP_PTR_HI;
                                        bit_state = BP_SND_ACK;
                                    end
                                    else
                                    begin
                                        bit_state = BP_SKIP_ACK;
                                    end
                                end
                                TP_PTR_HI:
                                begin
                                    reg_ptr = PTR_W'({shift_reg[0], 8'h00});
                                    xfer_state = TP_PTR_LO;
                                    bit_state = BP_SND_ACK;
                                end
                                TP_PTR_LO:
                                begin
                                    reg_ptr = reg_ptr | PTR_W'(shift_reg);
                                    xfer_state = TP_RX;
                                    bit_state = BP_SND_ACK;
                                end
                                TP_RX:
                                begin
                                    reg_image[reg_ptr] = shift_reg;
                                    reg_ptr = reg_ptr + 1'b1;
                                    bit_state = BP_SND_ACK;
                                end
                                default:
                                begin
                                    // byte while sending: dropped
                                end
                            endcase
                            shift_reg = '0;
                            shift_count = '0;
                        end
                    end
                    BP_SND_ACK:
                    begin
                        p[PIN_SDA_BIT] = 1'b1;
                        if (xfer_state == TP_TX)
                        begin
                            if (reg_ptr == touch_idx)
                                reg_image[reg_ptr] = s.touch_down ? touch_val : 8'h00;
                            shift_reg = reg_image[reg_ptr];
                            reg_ptr = reg_ptr + 1'b1;
                            bit_state = BP_SND;
                        end
                        else
                        begin
                            bit_state = BP_RCV;
                        end
                    end
                    BP_RCV_ACK:
                        bit_state = BP_SND;
                    default:
                        bit_state = BP_IDLE;
                endcase
            end
            else if (p[PIN_SDA_BIT] != last_pins[PIN_SDA_BIT] && p[PIN_SCL_BIT])
            begin
                if (p[PIN_SDA_BIT])
                begin
                    bit_state = BP_IDLE;
                end
                else
                begin
                    shift_reg = '0;
                    shift_count = '0;
                    bit_state = BP_RCV;
                    xfer_state = TP_ADDR;
                end
            end
        end
        last_pins = p;
        r.port_out = p;
        r.bus_phase = bit_state;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // pin request sender: at times a random idle burst, then hold valid until taken;
    // the expectation is queued by the same process at acceptance
    // ------------------------------------------------------------------------
    task automatic send_pin(input pin_req_t p, input logic check, input res_t want);
        res_t predicted;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            pin_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pin <= p;
        pin_valid <= 1'b1;
        @(posedge clk);
        while (!pin_ready)
            @(posedge clk);
        predicted = target_step(p);
        pending_results.push_back(check ? want : predicted);
        pins_sent++;
    endtask

    // one bus sample: reset pin high, scl/sda as given, other pins random
    function automatic pin_req_t bus_pins(logic scl, logic sda);
        pin_req_t s;
        s.port_value = 8'($urandom);
        s.port_value[PIN_RST_BIT] = 1'b1;
        s.port_value[PIN_SCL_BIT] = scl;
        s.port_value[PIN_SDA_BIT] = sda;
        s.touch_down = 1'($urandom_range(0, 1));
        return s;
    endfunction

    task automatic clock_bit(input logic sda);
        send_pin(bus_pins(1'b0, sda), 1'b0, '0);
        send_pin(bus_pins(1'b1, sda), 1'b0, '0);
    endtask

    task automatic send_byte(input logic [7:0] b);
        for (int k = 7; k >= 0; k--)
            clock_bit(b[k]);
    endtask

    task automatic bus_start();
        send_pin(bus_pins(1'b0, 1'b1), 1'b0, '0);
        send_pin(bus_pins(1'b1, 1'b1), 1'b0, '0);
        send_pin(bus_pins(1'b1, 1'b0), 1'b0, '0);
    endtask

    task automatic bus_stop();
        send_pin(bus_pins(1'b0, 1'b0), 1'b0, '0);
        send_pin(bus_pins(1'b1, 1'b0), 1'b0, '0);
        send_pin(bus_pins(1'b1, 1'b1), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // one bus transaction: write with data, pointer set then repeated-start
    // read, or read at the current pointer; pointers favor the touch
    // register and the wrap at the top of the store
    // ------------------------------------------------------------------------
    task automatic bus_transaction();
        logic [6:0] target;
        logic [6:0] junk;
        logic [8:0] ptr;
        int         kind;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            target = addr_a;
        else if (pick < 8)
            target = addr_b;
        else
            target = 7'($urandom_range(0, 127));
        kind = $urandom_range(0, 2);
        bus_start();
        send_byte({target, kind == 2});
        clock_bit(1'($urandom_range(0, 1)));
        if (kind != 2)
        begin
            case ($urandom_range(0, 3))
                0: ptr = 9'($urandom);
                1: ptr = touch_idx;
                2: ptr = 9'h1FE + 9'($urandom_range(0, 1));
                default: ptr = 9'($urandom_range(0, 7));
            endcase
            junk = 7'($urandom);
            // only bit 0 of the high pointer byte counts
            send_byte({junk, ptr[8]});
            clock_bit(1'($urandom_range(0, 1)));
            send_byte(ptr[7:0]);
            clock_bit(1'($urandom_range(0, 1)));
            if (kind == 0)
            begin
                repeat ($urandom_range(0, 3))
                begin
                    send_byte(8'($urandom));
                    clock_bit(1'($urandom_range(0, 1)));
                end
            end
            else
            begin
                // repeated start into a read
                bus_start();
                send_byte({target, 1'b1});
                clock_bit(1'($urandom_range(0, 1)));
            end
        end
        if (kind != 0)
        begin
            repeat ($urandom_range(1, 3))
            begin
                repeat (8) clock_bit(1'($urandom_range(0, 1)));
                clock_bit(1'($urandom_range(0, 1)));
            end
        end
        if ($urandom_range(0, 7) != 0)
            bus_stop();
    endtask

    // mostly well-formed transactions, some noise and cut-off sequences
    task automatic random_traffic(input int goal);
        int pick;
        pin_req_t s;
        while (pins_sent < goal)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    s.port_value = 8'($urandom);
                    s.touch_down = 1'($urandom_range(0, 1));
                    send_pin(s, 1'b0, '0);
                end
            end
            else if (pick == 1)
            begin
                bus_start();
                repeat ($urandom_range(1, 12)) clock_bit(1'($urandom_range(0, 1)));
                if ($urandom_range(0, 1) != 0)
                    bus_stop();
            end
            else
            begin
                bus_transaction();
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // settings port
    // ------------------------------------------------------------------------
    task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_DEV_ADDR_A: addr_a = value[6:0];
            CFG_DEV_ADDR_B: addr_b = value[6:0];
            CFG_TOUCH_IDX:  touch_idx = value[8:0];
            CFG_TOUCH_VAL:  touch_val = value[7:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // drain all results, then write all four registers; unused data bits
    // carry random junk that the block must drop
    task automatic set_config(input logic [6:0] a, input logic [6:0] b,
                              input logic [8:0] ti, input logic [7:0] tv);
        logic [1:0] junk_a;
        logic [1:0] junk_b;
        logic       junk_v;
        junk_a = 2'($urandom);
        junk_b = 2'($urandom);
        junk_v = 1'($urandom);
        pin_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_setting(CFG_DEV_ADDR_A, {junk_a, a});
        write_setting(CFG_DEV_ADDR_B, {junk_b, b});
        write_setting(CFG_TOUCH_IDX, ti);
        write_setting(CFG_TOUCH_VAL, {junk_v, tv});
    endtask

    // ------------------------------------------------------------------------
    // result receiver: random stall bursts, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (hold_long)
            begin
                hold_long = 1'b0;
                res_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                res_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                res_ready <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // result checker: each taken result against the oldest expectation
    // ------------------------------------------------------------------------
    res_t oldest;

    task automatic report_mismatch(input string what, input res_t want, input res_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t (%s): expected %h/%0d, got %h/%0d (port_out/bus_phase)",
                     $realtime, what, want.port_out, want.bus_phase, got.port_out,
                     got.bus_phase);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("no request waiting", '0, res);
            end
            else
            begin
                oldest = pending_results.pop_front();
                if (res.port_out !== oldest.port_out || res.bus_phase !== oldest.bus_phase)
                    report_mismatch("field", oldest, res);
            end
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [6:0] shared_addr;
        // predictor starts from the reset state
        addr_a = DEV_ADDR_A_RST;
        addr_b = DEV_ADDR_B_RST;
        touch_idx = TOUCH_IDX_RST;
        touch_val = TOUCH_VAL_RST;
        bit_state = BP_IDLE;
        xfer_state = TP_ADDR;
        shift_reg = '0;
        shift_count = '0;
        reg_ptr = '0;
        last_pins = '0;
        for (int k = 0; k < STORE_DEPTH; k++)
            reg_image[k] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows; the store sweep after reset holds off the first one
        for (int row = 0; row < 25; row++)
            send_pin(directed_rows[row].req, directed_rows[row].check, directed_rows[row].want);

        random_traffic(400);

        // extremes one way, with the long receiver hold-off
        set_config(7'h00, 7'h7F, 9'h000, 8'h00);
        hold_long = 1'b1;
        random_traffic(700);

        // extremes the other way
        set_config(7'h7F, 7'h00, 9'h1FF, 8'hFF);
        random_traffic(1000);

        // both addresses equal
        shared_addr = 7'($urandom_range(0, 127));
        set_config(shared_addr, shared_addr, 9'($urandom_range(0, 511)),
                   8'($urandom_range(0, 255)));
        random_traffic(1300);

        // random settings, no idling from here on
        set_config(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                   9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        quiet = 1'b1;
        random_traffic(1700);

        pin_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #4000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

>>> i2c_target_register_file_top.f
rtl/i2ctrf_pkg.sv
rtl/i2ctrf_front.sv
rtl/i2ctrf_back.sv
rtl/i2c_target_register_file_top.sv
test/tb_i2c_target_register_file_top.sv
